@@ rtl/ngate_pkg.sv @@
package ngate_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 24;
  localparam int HOLD_BITS   = 16;

  localparam int THR_BITS   = SAMPLE_BITS - 1;
  localparam int THR2_BITS  = 2 * THR_BITS;
  localparam int SQ_BITS    = 2 * SAMPLE_BITS;
  localparam int GAIN_BITS  = COEFF_BITS + 1;
  localparam int MUL_A_BITS = (SQ_BITS - COEFF_BITS > COEFF_BITS) ? SQ_BITS - COEFF_BITS
                                                                   : COEFF_BITS;
  localparam int MUL_B_BITS = (GAIN_BITS > SAMPLE_BITS) ? GAIN_BITS : SAMPLE_BITS;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  localparam int CFG_WIDE1    = (COEFF_BITS > THR_BITS) ? COEFF_BITS : THR_BITS;
  localparam int CFG_BITS     = (CFG_WIDE1 > HOLD_BITS) ? CFG_WIDE1 : HOLD_BITS;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [63:0] CLOSE_RATIO_Q32 = 64'd2709941161;
  localparam logic [63:0] FLOOR_GAIN_Q32  = 64'd241523760;
  localparam logic [COEFF_BITS-1:0] CLOSE_RATIO =
    COEFF_BITS'(CLOSE_RATIO_Q32 >> (32 - COEFF_BITS));
  localparam logic [GAIN_BITS-1:0] FLOOR_GAIN =
    GAIN_BITS'(FLOOR_GAIN_Q32 >> (32 - COEFF_BITS));
  localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(1) << COEFF_BITS;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HOLD   = 2'd2
  } gate_mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GATE_ENABLE  = 3'd0,
    REG_OPEN_LEVEL   = 3'd1,
    REG_GAIN_ATTACK  = 3'd2,
    REG_GAIN_RELEASE = 3'd3,
    REG_PEAK_ATTACK  = 3'd4,
    REG_PEAK_RELEASE = 3'd5,
    REG_RMS_COEFF    = 3'd6,
    REG_HOLD_SAMPLES = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                  enable;
    logic [THR_BITS-1:0]   open_level;
    logic [COEFF_BITS-1:0] gain_attack;
    logic [COEFF_BITS-1:0] gain_release;
    logic [COEFF_BITS-1:0] peak_attack;
    logic [COEFF_BITS-1:0] peak_release;
    logic [COEFF_BITS-1:0] rms_coeff;
    logic [HOLD_BITS-1:0]  hold_samples;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:       1'b1,
    open_level:   THR_BITS'(33408),
    gain_attack:  COEFF_BITS'(16078123),
    gain_release: COEFF_BITS'(16774306),
    peak_attack:  COEFF_BITS'(13210000),
    peak_release: COEFF_BITS'(16742300),
    rms_coeff:    COEFF_BITS'(16707400),
    hold_samples: HOLD_BITS'(1200)
  };

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic [GAIN_BITS-1:0]   gain;
    gate_mode_e             mode;
  } frame_res_t;

  typedef struct packed {
    logic in_valid;
    logic gate_enable;
    logic out_busy;
  } seq_cond_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RECT,
    OP_SETUP_PEAK,
    OP_SETUP_SQ,
    OP_SETUP_GAIN,
    OP_WB_PEAK,
    OP_WB_SQ,
    OP_WB_GAIN,
    OP_MODE,
    OP_BYPASS,
    OP_COMMIT
  } op_e;

  typedef enum logic [2:0] {
    A_ZERO,
    A_RECT,
    A_DIFF_HI,
    A_DIFF_LO,
    A_THR,
    A_CLOSE,
    A_ABS_L,
    A_ABS_R
  } a_sel_e;

  typedef enum logic [3:0] {
    B_ZERO,
    B_RECT,
    B_PEAK_C,
    B_RMS_C,
    B_GAIN_C,
    B_THR,
    B_RATIO,
    B_CLOSE,
    B_GAIN
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_e;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_M2,
    ST_THR2,
    ST_CLOSE,
    ST_CLOSE2,
    ST_OUT_L,
    ST_OUT_R
  } st_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT,
    JMP_ALWAYS
  } jmp_e;

  localparam int NUM_STEPS = 23;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  localparam logic [STEP_W-1:0] STEP_IDLE       = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_RECT       = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_PEAK_SETUP = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_PEAK_HI    = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_PEAK_LO    = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_PEAK_ADD   = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_PEAK_WB    = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_SQ_SETUP   = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_SQ_HI      = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_SQ_LO      = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_SQ_ADD     = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_SQ_WB      = STEP_W'(11);
  localparam logic [STEP_W-1:0] STEP_MODE       = STEP_W'(12);
  localparam logic [STEP_W-1:0] STEP_GAIN_SETUP = STEP_W'(13);
  localparam logic [STEP_W-1:0] STEP_GAIN_HI    = STEP_W'(14);
  localparam logic [STEP_W-1:0] STEP_GAIN_LO    = STEP_W'(15);
  localparam logic [STEP_W-1:0] STEP_GAIN_ADD   = STEP_W'(16);
  localparam logic [STEP_W-1:0] STEP_GAIN_WB    = STEP_W'(17);
  localparam logic [STEP_W-1:0] STEP_SCALE_L    = STEP_W'(18);
  localparam logic [STEP_W-1:0] STEP_SCALE_R    = STEP_W'(19);
  localparam logic [STEP_W-1:0] STEP_STORE_R    = STEP_W'(20);
  localparam logic [STEP_W-1:0] STEP_COMMIT     = STEP_W'(21);
  localparam logic [STEP_W-1:0] STEP_BYPASS     = STEP_W'(22);

  typedef struct packed {
    op_e               op;
    a_sel_e            a_sel;
    b_sel_e            b_sel;
    acc_e              acc;
    st_e               st;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    op:     OP_NOP,
    a_sel:  A_ZERO,
    b_sel:  B_ZERO,
    acc:    ACC_HOLD,
    st:     ST_NONE,
    jmp:    JMP_NEXT,
    target: STEP_IDLE
  };

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (step)
      STEP_IDLE: begin
        w.op     = OP_LOAD;
        w.jmp    = JMP_WAIT_IN;
        w.target = STEP_BYPASS;
      end
      STEP_RECT: w.op = OP_RECT;
      STEP_PEAK_SETUP: begin
        w.a_sel = A_RECT;
        w.b_sel = B_RECT;
        w.op    = OP_SETUP_PEAK;
      end
      STEP_PEAK_HI: begin
        w.a_sel = A_DIFF_HI;
        w.b_sel = B_PEAK_C;
        w.st    = ST_M2;
      end
      STEP_PEAK_LO: begin
        w.a_sel = A_DIFF_LO;
        w.b_sel = B_PEAK_C;
        w.acc   = ACC_LOAD;
      end
      STEP_PEAK_ADD: begin
        w.a_sel = A_THR;
        w.b_sel = B_THR;
        w.acc   = ACC_ADD;
      end
      STEP_PEAK_WB: begin
        w.a_sel = A_THR;
        w.b_sel = B_RATIO;
        w.op    = OP_WB_PEAK;
        w.st    = ST_THR2;
      end
      STEP_SQ_SETUP: begin
        w.op = OP_SETUP_SQ;
        w.st = ST_CLOSE;
      end
      STEP_SQ_HI: begin
        w.a_sel = A_DIFF_HI;
        w.b_sel = B_RMS_C;
      end
      STEP_SQ_LO: begin
        w.a_sel = A_DIFF_LO;
        w.b_sel = B_RMS_C;
        w.acc   = ACC_LOAD;
      end
      STEP_SQ_ADD: begin
        w.a_sel = A_CLOSE;
        w.b_sel = B_CLOSE;
        w.acc   = ACC_ADD;
      end
      STEP_SQ_WB: begin
        w.op = OP_WB_SQ;
        w.st = ST_CLOSE2;
      end
      STEP_MODE:       w.op = OP_MODE;
      STEP_GAIN_SETUP: w.op = OP_SETUP_GAIN;
      STEP_GAIN_HI: begin
        w.a_sel = A_DIFF_HI;
        w.b_sel = B_GAIN_C;
      end
      STEP_GAIN_LO: begin
        w.a_sel = A_DIFF_LO;
        w.b_sel = B_GAIN_C;
        w.acc   = ACC_LOAD;
      end
      STEP_GAIN_ADD: w.acc = ACC_ADD;
      STEP_GAIN_WB:  w.op  = OP_WB_GAIN;
      STEP_SCALE_L: begin
        w.a_sel = A_ABS_L;
        w.b_sel = B_GAIN;
      end
      STEP_SCALE_R: begin
        w.a_sel = A_ABS_R;
        w.b_sel = B_GAIN;
        w.st    = ST_OUT_L;
      end
      STEP_STORE_R: w.st = ST_OUT_R;
      STEP_COMMIT: begin
        w.op     = OP_COMMIT;
        w.jmp    = JMP_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      STEP_BYPASS: begin
        w.op     = OP_BYPASS;
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_COMMIT;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/ngate_seq.sv @@
module ngate_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ngate_pkg::seq_cond_t cond_i,
  output ngate_pkg::ctrl_t     ctrl_o,
  output logic                 ready_o
);
  import ngate_pkg::*;

  logic [STEP_W-1:0] pc_q, pc_d;
  ctrl_t             word;
  logic              fire;

  always_comb begin
    word = ucode(pc_q);
    fire = 1'b1;
    pc_d = pc_q + STEP_W'(1);
    unique case (word.jmp)
      JMP_NEXT: ;
      JMP_WAIT_IN: begin
        fire = cond_i.in_valid;
        if (!fire) begin
          pc_d = pc_q;
        end else if (!cond_i.gate_enable) begin
          pc_d = word.target;
        end
      end
      JMP_WAIT_OUT: begin
        fire = !cond_i.out_busy;
        pc_d = fire ? word.target : pc_q;
      end
      JMP_ALWAYS: pc_d = word.target;
      default:    pc_d = STEP_IDLE;
    endcase
    ctrl_o = word;
    if (!fire) begin
      ctrl_o.op = OP_NOP;
    end
  end

  assign ready_o = (word.jmp == JMP_WAIT_IN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ rtl/ngate_dp.sv @@
module ngate_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ngate_pkg::ctrl_t                        ctrl_i,
  input  ngate_pkg::cfg_t                         cfg_i,
  input  logic signed [ngate_pkg::SAMPLE_BITS-1:0] side_left_i,
  input  logic signed [ngate_pkg::SAMPLE_BITS-1:0] side_right_i,
  input  logic signed [ngate_pkg::SAMPLE_BITS-1:0] audio_left_i,
  input  logic signed [ngate_pkg::SAMPLE_BITS-1:0] audio_right_i,
  output ngate_pkg::frame_res_t                   res_o
);
  import ngate_pkg::*;

  logic [SAMPLE_BITS-1:0] mono_q, mono_d;
  logic [SAMPLE_BITS-1:0] al_q, al_d, ar_q, ar_d;
  logic [SAMPLE_BITS-1:0] rect_q, rect_d;
  logic [SAMPLE_BITS-1:0] abs_l_q, abs_l_d, abs_r_q, abs_r_d;
  logic                   sgn_l_q, sgn_l_d, sgn_r_q, sgn_r_d;
  logic [SQ_BITS-1:0]     m2_q, m2_d;
  logic [THR2_BITS-1:0]   thr2_q, thr2_d, close2_q, close2_d;
  logic [THR_BITS-1:0]    close_q, close_d;
  logic [SQ_BITS-1:0]     tgt_q, tgt_d, diff_q, diff_d, acc_q, acc_d;
  logic                   dir_q, dir_d;
  logic [PROD_BITS-1:0]   prod_q, prod_d;
  logic [SAMPLE_BITS-1:0] gl_q, gl_d, gr_q, gr_d;

  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [SQ_BITS-1:0]     sq_q, sq_d;
  logic [GAIN_BITS-1:0]   gain_q, gain_d;
  gate_mode_e             mode_q, mode_d;
  logic [HOLD_BITS-1:0]   hold_q, hold_d;

  logic [SAMPLE_BITS:0]   side_sum;
  logic [SQ_BITS-1:0]     set_y, set_t, glide_res;
  logic                   set_ge;
  logic [MUL_A_BITS-1:0]  mul_a;
  logic [MUL_B_BITS-1:0]  mul_b;
  logic [SAMPLE_BITS-1:0] scaled;
  logic                   above, below;

  assign side_sum = {side_left_i[SAMPLE_BITS-1], side_left_i}
                  + {side_right_i[SAMPLE_BITS-1], side_right_i};

  always_comb begin
    case (ctrl_i.op)
      OP_SETUP_SQ: begin
        set_y = sq_q;
        set_t = m2_q;
      end
      OP_SETUP_GAIN: begin
        set_y = SQ_BITS'(gain_q);
        set_t = (mode_q == MODE_CLOSED) ? SQ_BITS'(FLOOR_GAIN) : SQ_BITS'(UNITY_GAIN);
      end
      default: begin
        set_y = SQ_BITS'(peak_q);
        set_t = SQ_BITS'(rect_q);
      end
    endcase
  end

  assign set_ge    = (set_y >= set_t);
  assign glide_res = dir_q ? tgt_q + acc_q : tgt_q - acc_q;

  always_comb begin
    case (ctrl_i.a_sel)
      A_RECT:    mul_a = MUL_A_BITS'(rect_q);
      A_DIFF_HI: mul_a = MUL_A_BITS'(diff_q[SQ_BITS-1:COEFF_BITS]);
      A_DIFF_LO: mul_a = MUL_A_BITS'(diff_q[COEFF_BITS-1:0]);
      A_THR:     mul_a = MUL_A_BITS'(cfg_i.open_level);
      A_CLOSE:   mul_a = MUL_A_BITS'(close_q);
      A_ABS_L:   mul_a = MUL_A_BITS'(abs_l_q);
      A_ABS_R:   mul_a = MUL_A_BITS'(abs_r_q);
      default:   mul_a = '0;
    endcase
    case (ctrl_i.b_sel)
      B_RECT:   mul_b = MUL_B_BITS'(rect_q);
      B_PEAK_C: mul_b = MUL_B_BITS'(dir_q ? cfg_i.peak_release : cfg_i.peak_attack);
      B_RMS_C:  mul_b = MUL_B_BITS'(cfg_i.rms_coeff);
      B_GAIN_C: mul_b = MUL_B_BITS'(dir_q ? cfg_i.gain_release : cfg_i.gain_attack);
      B_THR:    mul_b = MUL_B_BITS'(cfg_i.open_level);
      B_RATIO:  mul_b = MUL_B_BITS'(CLOSE_RATIO);
      B_CLOSE:  mul_b = MUL_B_BITS'(close_q);
      B_GAIN:   mul_b = MUL_B_BITS'(gain_q);
      default:  mul_b = '0;
    endcase
  end

  assign prod_d = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  assign scaled = prod_q[COEFF_BITS +: SAMPLE_BITS];

  always_comb begin
    mono_d   = mono_q;
    al_d     = al_q;
    ar_d     = ar_q;
    rect_d   = rect_q;
    abs_l_d  = abs_l_q;
    abs_r_d  = abs_r_q;
    sgn_l_d  = sgn_l_q;
    sgn_r_d  = sgn_r_q;
    tgt_d    = tgt_q;
    diff_d   = diff_q;
    dir_d    = dir_q;
    m2_d     = m2_q;
    thr2_d   = thr2_q;
    close_d  = close_q;
    close2_d = close2_q;
    acc_d    = acc_q;
    gl_d     = gl_q;
    gr_d     = gr_q;
    peak_d   = peak_q;
    sq_d     = sq_q;
    gain_d   = gain_q;
    unique case (ctrl_i.op)
      OP_LOAD: begin
        mono_d = side_sum[SAMPLE_BITS:1];
        al_d   = audio_left_i;
        ar_d   = audio_right_i;
      end
      OP_RECT: begin
        rect_d  = mono_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-mono_q) : mono_q;
        abs_l_d = al_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-al_q) : al_q;
        abs_r_d = ar_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ar_q) : ar_q;
        sgn_l_d = al_q[SAMPLE_BITS-1];
        sgn_r_d = ar_q[SAMPLE_BITS-1];
      end
      OP_SETUP_PEAK, OP_SETUP_SQ, OP_SETUP_GAIN: begin
        tgt_d  = set_t;
        dir_d  = set_ge;
        diff_d = set_ge ? set_y - set_t : set_t - set_y;
      end
      OP_WB_PEAK: peak_d = glide_res[SAMPLE_BITS-1:0];
      OP_WB_SQ:   sq_d   = glide_res;
      OP_WB_GAIN: gain_d = glide_res[GAIN_BITS-1:0];
      OP_BYPASS: begin
        gain_d = UNITY_GAIN;
        gl_d   = al_q;
        gr_d   = ar_q;
      end
      default: ;
    endcase
    case (ctrl_i.acc)
      ACC_LOAD: acc_d = prod_q[SQ_BITS-1:0];
      ACC_ADD:  acc_d = acc_q + SQ_BITS'(prod_q >> COEFF_BITS);
      default:  ;
    endcase
    case (ctrl_i.st)
      ST_M2:     m2_d     = prod_q[SQ_BITS-1:0];
      ST_THR2:   thr2_d   = prod_q[THR2_BITS-1:0];
      ST_CLOSE:  close_d  = prod_q[COEFF_BITS +: THR_BITS];
      ST_CLOSE2: close2_d = prod_q[THR2_BITS-1:0];
      ST_OUT_L:  gl_d     = sgn_l_q ? SAMPLE_BITS'(-scaled) : scaled;
      ST_OUT_R:  gr_d     = sgn_r_q ? SAMPLE_BITS'(-scaled) : scaled;
      default:   ;
    endcase
  end

  assign above = (peak_q > SAMPLE_BITS'(cfg_i.open_level)) || (sq_q > SQ_BITS'(thr2_q));
  assign below = (peak_q < SAMPLE_BITS'(close_q)) && (sq_q < SQ_BITS'(close2_q));

  always_comb begin
    mode_d = mode_q;
    hold_d = hold_q;
    if (ctrl_i.op == OP_BYPASS) begin
      mode_d = MODE_CLOSED;
    end else if (ctrl_i.op == OP_MODE) begin
      unique case (mode_q)
        MODE_OPEN: begin
          if (below) begin
            mode_d = MODE_HOLD;
            hold_d = cfg_i.hold_samples;
          end
        end
        MODE_HOLD: begin
          if (above) begin
            mode_d = MODE_OPEN;
          end else if (hold_q <= HOLD_BITS'(1)) begin
            mode_d = MODE_CLOSED;
            hold_d = '0;
          end else begin
            hold_d = hold_q - HOLD_BITS'(1);
          end
        end
        default: begin
          mode_d = above ? MODE_OPEN : MODE_CLOSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      sq_q   <= '0;
      gain_q <= UNITY_GAIN;
      mode_q <= MODE_CLOSED;
      hold_q <= '0;
    end else begin
      peak_q <= peak_d;
      sq_q   <= sq_d;
      gain_q <= gain_d;
      mode_q <= mode_d;
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mono_q   <= mono_d;
    al_q     <= al_d;
    ar_q     <= ar_d;
    rect_q   <= rect_d;
    abs_l_q  <= abs_l_d;
    abs_r_q  <= abs_r_d;
    sgn_l_q  <= sgn_l_d;
    sgn_r_q  <= sgn_r_d;
    tgt_q    <= tgt_d;
    diff_q   <= diff_d;
    dir_q    <= dir_d;
    m2_q     <= m2_d;
    thr2_q   <= thr2_d;
    close_q  <= close_d;
    close2_q <= close2_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    gl_q     <= gl_d;
    gr_q     <= gr_d;
  end

  assign res_o.left  = gl_q;
  assign res_o.right = gr_q;
  assign res_o.gain  = gain_q;
  assign res_o.mode  = mode_q;

endmodule

@@ rtl/noise_gate_hysteresis_hold.sv @@
// Stereo noise gate with hysteresis and hold.
// Input channel: in_valid_i / in_stall_o carry one frame item of two side-chain
// samples and two audio samples. Output channel: out_valid_o / out_stall_i carry
// the gated stereo pair, the applied gain and the gate phase. Either side
// moves an item at a clock edge with valid high and stall low.
// Configuration: write cfg_data_i into register cfg_index_i while cfg_we_i is
// high; write only while no item is in flight.
// Operation: with the gate enabled the control program steps one shared 24x25
// multiplier through the envelopes, the thresholds, the gain glide and the two
// output products; disabled, the audio passes at unity gain and the gate
// closes. A new item is taken only once the last one has been committed to
// the output register.
// Reset clears the envelopes and the hold counter, sets the gain to unity,
// the gate closed and the configuration registers to their defaults.
// A stalled receiver holds the result in the output register; the next item
// is still taken and worked on, and its result waits until the register frees.
module noise_gate_hysteresis_hold (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [ngate_pkg::SAMPLE_BITS-1:0]  side_left_i,
  input  logic signed [ngate_pkg::SAMPLE_BITS-1:0]  side_right_i,
  input  logic signed [ngate_pkg::SAMPLE_BITS-1:0]  audio_left_i,
  input  logic signed [ngate_pkg::SAMPLE_BITS-1:0]  audio_right_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [ngate_pkg::SAMPLE_BITS-1:0]  gated_left_o,
  output logic signed [ngate_pkg::SAMPLE_BITS-1:0]  gated_right_o,
  output logic        [ngate_pkg::GAIN_BITS-1:0]    current_gain_o,
  output logic        [1:0]                        gate_phase_o,
  input  logic                                     cfg_we_i,
  input  logic        [ngate_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic        [ngate_pkg::CFG_BITS-1:0]     cfg_data_i
);
  import ngate_pkg::*;

  cfg_t       cfg_q;
  ctrl_t      ctrl;
  seq_cond_t  cond;
  logic       ready;
  frame_res_t res;
  frame_res_t out_q;
  logic       out_valid_q;
  logic       commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GATE_ENABLE:  cfg_q.enable       <= cfg_data_i[0];
        REG_OPEN_LEVEL:   cfg_q.open_level   <= cfg_data_i[THR_BITS-1:0];
        REG_GAIN_ATTACK:  cfg_q.gain_attack  <= cfg_data_i[COEFF_BITS-1:0];
        REG_GAIN_RELEASE: cfg_q.gain_release <= cfg_data_i[COEFF_BITS-1:0];
        REG_PEAK_ATTACK:  cfg_q.peak_attack  <= cfg_data_i[COEFF_BITS-1:0];
        REG_PEAK_RELEASE: cfg_q.peak_release <= cfg_data_i[COEFF_BITS-1:0];
        REG_RMS_COEFF:    cfg_q.rms_coeff    <= cfg_data_i[COEFF_BITS-1:0];
        REG_HOLD_SAMPLES: cfg_q.hold_samples <= cfg_data_i[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cond.in_valid    = in_valid_i;
  assign cond.gate_enable = cfg_q.enable;
  assign cond.out_busy    = out_valid_q && out_stall_i;

  ngate_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cond_i  (cond),
    .ctrl_o  (ctrl),
    .ready_o (ready)
  );

  ngate_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .side_left_i   (side_left_i),
    .side_right_i  (side_right_i),
    .audio_left_i  (audio_left_i),
    .audio_right_i (audio_right_i),
    .res_o         (res)
  );

  assign in_stall_o = !ready;
  assign commit     = (ctrl.op == OP_COMMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gated_left_o   = out_q.left;
  assign gated_right_o  = out_q.right;
  assign current_gain_o = out_q.gain;
  assign gate_phase_o   = out_q.mode;

endmodule
